@@ hdl/tcw_pkg.sv @@
// Shared types and constants for the text console character writer.
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] TEXT_ATTR  = 8'h07;
  localparam logic [15:0]       BLANK_CELL = {TEXT_ATTR, BLANK_CHAR};

  typedef enum logic [1:0] {
    SW_NONE  = 2'd0,
    SW_COPY  = 2'd1,
    SW_BLANK = 2'd2
  } sweep_mode_t;

  typedef struct packed {
    logic        accept;
    logic        load_read;
    logic        sweep_zero;
    logic        sweep_step;
    sweep_mode_t mode;
  } tcw_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic copy_last;
    logic blank_last;
  } tcw_stat_t;

endpackage

@@ hdl/tcw_item_if.sv @@
// Input channel: one console command per transaction.
interface tcw_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, kind, char_code, cell_index, input ready);
  modport sink (input valid, kind, char_code, cell_index, output ready);
endinterface

@@ hdl/tcw_result_if.sv @@
// Output channel: one result per command transaction.
interface tcw_result_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_pos;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
  modport sink (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

@@ hdl/tcw_datapath.sv @@
// Screen store, cursor, sweep counter and result register.
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         kind,
  input  logic [7:0]         char_code,
  input  logic [10:0]        cell_index,
  input  tcw_pkg::tcw_cmd_t  cmd,
  output tcw_pkg::tcw_stat_t stat,
  output logic [10:0]        cursor_pos,
  output logic [7:0]         cell_char,
  output logic [7:0]         cell_attr
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  // Wide enough to hold the cell count itself for the range compare.
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] col, col_next;
  logic [AW-1:0] sweep;
  logic          copy_pend;
  logic [AW-1:0] copy_addr;
  logic          rd_ok;
  logic          in_range;

  logic          put_we;
  logic [AW-1:0] put_addr;
  logic [15:0]   put_data;
  logic          scroll;
  logic          last_row;
  logic          col_last;
  logic          is_put;
  logic          blank_hold;

  assign last_row   = pos >= AW'(CELLS - COLUMNS);
  assign col_last   = col == CW'(COLUMNS - 1);
  assign is_put     = cmd.accept && (kind == KIND_PUT);
  assign in_range   = IW'(cell_index) < IW'(CELLS);
  // A pending copy write owns the write port; the blank sweep waits.
  assign blank_hold = (cmd.mode == SW_BLANK) && copy_pend;

  always_comb begin
    pos_next = pos;
    col_next = col;
    put_we   = 1'b0;
    put_addr = pos;
    put_data = {TEXT_ATTR, char_code};
    scroll   = 1'b0;
    case (char_code)
      CH_NL: begin
        col_next = '0;
        if (last_row) begin
          scroll   = 1'b1;
          pos_next = AW'(CELLS - COLUMNS);
        end else begin
          pos_next = pos - AW'(col) + AW'(COLUMNS);
        end
      end
      CH_CR: begin
        col_next = '0;
        pos_next = pos - AW'(col);
      end
      CH_BS: begin
        if (col != '0) begin
          col_next = col - CW'(1);
          pos_next = pos - AW'(1);
          put_we   = 1'b1;
          put_addr = pos - AW'(1);
          put_data = BLANK_CELL;
        end
      end
      default: begin
        put_we = 1'b1;
        if (col_last) begin
          col_next = '0;
          if (last_row) begin
            scroll   = 1'b1;
            pos_next = AW'(CELLS - COLUMNS);
          end else begin
            pos_next = pos + AW'(1);
          end
        end else begin
          col_next = col + CW'(1);
          pos_next = pos + AW'(1);
        end
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = sweep;
    wdata = BLANK_CELL;
    if (copy_pend) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rdata;
    end else if (cmd.mode == SW_BLANK) begin
      we = 1'b1;
    end else if (is_put && put_we) begin
      we    = 1'b1;
      waddr = put_addr;
      wdata = put_data;
    end
  end

  assign raddr = (cmd.mode == SW_COPY) ? (sweep + AW'(COLUMNS)) : AW'(IW'(cell_index));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      col       <= '0;
      sweep     <= '0;
      copy_pend <= 1'b0;
    end else begin
      copy_pend <= (cmd.mode == SW_COPY);
      if (cmd.sweep_zero) begin
        sweep <= '0;
      end else if (cmd.sweep_step && !blank_hold) begin
        sweep <= sweep + AW'(1);
      end
      if (is_put) begin
        pos <= pos_next;
        col <= col_next;
      end else if (cmd.accept && (kind == KIND_CLEAR)) begin
        pos <= '0;
        col <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= sweep;
    if (cmd.accept) begin
      rd_ok     <= in_range;
      cell_char <= '0;
      cell_attr <= '0;
      case (kind)
        KIND_PUT:   cursor_pos <= POS_W'(pos_next);
        KIND_CLEAR: cursor_pos <= '0;
        default:    cursor_pos <= POS_W'(pos);
      endcase
    end else if (cmd.load_read) begin
      cell_char <= rd_ok ? rdata[7:0] : '0;
      cell_attr <= rd_ok ? rdata[15:8] : '0;
    end
  end

  assign stat.need_scroll = scroll;
  assign stat.copy_last   = sweep == AW'(CELLS - COLUMNS - 1);
  assign stat.blank_last  = (cmd.mode == SW_BLANK) && !copy_pend && (sweep == AW'(CELLS - 1));

endmodule

@@ hdl/tcw_controller.sv @@
// Sequencer: handshakes, result valid flag and the scroll and clear sweeps.
module tcw_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [1:0]         item_kind,
  output logic               item_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t  cmd
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_COPY  = 4'b0100,
    ST_BLANK = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   load_res;
  logic   result_valid_next;

  assign item_ready = (state == ST_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next     = state;
    cmd.accept     = 1'b0;
    cmd.load_read  = 1'b0;
    cmd.sweep_zero = 1'b0;
    cmd.sweep_step = 1'b0;
    cmd.mode       = SW_NONE;
    load_res       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          case (item_kind)
            KIND_PUT: begin
              load_res = 1'b1;
              if (stat.need_scroll) begin
                cmd.sweep_zero = 1'b1;
                state_next     = ST_COPY;
              end
            end
            KIND_CLEAR: begin
              load_res       = 1'b1;
              cmd.sweep_zero = 1'b1;
              state_next     = ST_BLANK;
            end
            KIND_READ: state_next = ST_READ;
            default:   load_res   = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        load_res      = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_COPY: begin
        cmd.mode       = SW_COPY;
        cmd.sweep_step = 1'b1;
        if (stat.copy_last) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.mode       = SW_BLANK;
        cmd.sweep_step = 1'b1;
        if (stat.blank_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (load_res) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_BLANK;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

@@ hdl/text_console_char_writer.sv @@
// Text console engine: character/attribute screen store with a cursor.
// After reset the block blanks the whole screen store before it takes its first
// transaction. A put that neither wraps off the last row nor ends in a newline
// there, and an unused kind, leave the sequencer idle; a read passes through a
// read state, as the screen store has one registered read port. A put that
// scrolls holds the input while one store cell is copied per cycle over the
// single write port, then the last row is blanked. A clear holds it while the
// whole store is blanked, one cell per cycle. Each result sits in an output
// register; the next transaction can be taken in the same cycle that the
// waiting result is taken.
module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input logic   clk,
  input logic   rst,
  tcw_item_if.sink     item,
  tcw_result_if.source result
);
  import tcw_pkg::*;

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_controller u_ctl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_kind    (item.kind),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .kind       (item.kind),
    .char_code  (item.char_code),
    .cell_index (item.cell_index),
    .cmd        (cmd),
    .stat       (stat),
    .cursor_pos (result.cursor_pos),
    .cell_char  (result.cell_char),
    .cell_attr  (result.cell_attr)
  );

endmodule

@@ tb/tb_text_console_char_writer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer: scoreboard, stimulus and checks.
module tb_text_console_char_writer;
  import tcw_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEFAULT;
  localparam int ROWS         = ROWS_DEFAULT;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int PHASE_ITEMS  = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } console_result_t;

  // Shadow screen and cursor; one expected result per accepted transaction.
  class console_scoreboard;
    logic [15:0]     screen [CELLS];
    int unsigned     col;
    int unsigned     row;
    console_result_t pending [$];
    int checked, mismatches, unexpected, reported;
    int scrolls, clears, reads, off_screen_reads;

    function new();
      blank_screen();
      col = 0;
      row = 0;
      checked = 0;
      mismatches = 0;
      unexpected = 0;
      reported = 0;
      scrolls = 0;
      clears = 0;
      reads = 0;
      off_screen_reads = 0;
    endfunction

    function void blank_screen();
      foreach (screen[i]) screen[i] = BLANK_CELL;
    endfunction

    function logic [POS_W-1:0] cursor();
      logic [31:0] p;
      p = row * COLUMNS + col;
      return p[POS_W-1:0];
    endfunction

    function void note_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] idx);
      console_result_t r;
      r = '0;
      case (k)
        KIND_PUT: begin
          if (ch == CH_NL) begin
            col = 0;
            row++;
          end else if (ch == CH_CR) begin
            col = 0;
          end else if (ch == CH_BS) begin
            // nothing happens at column zero
            if (col > 0) begin
              col--;
              screen[row * COLUMNS + col] = BLANK_CELL;
            end
          end else begin
            screen[row * COLUMNS + col] = {TEXT_ATTR, ch};
            col++;
          end
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
            row = ROWS - 1;
            scrolls++;
          end
        end
        KIND_CLEAR: begin
          blank_screen();
          col = 0;
          row = 0;
          clears++;
        end
        KIND_READ: begin
          reads++;
          if (idx < CELLS) begin
            r.cell_char = screen[idx][7:0];
            r.cell_attr = screen[idx][15:8];
          end else begin
            off_screen_reads++;
          end
        end
        default: ;
      endcase
      r.cursor_pos = cursor();
      pending.push_back(r);
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      checked++;
      if (pending.size() == 0) begin
        unexpected++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("[%0t] unexpected result: pos=%0d char=%02h attr=%02h", $time,
                   got.cursor_pos, got.cell_char, got.cell_attr);
        end
        return;
      end
      want = pending.pop_front();
      if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
          got.cell_attr !== want.cell_attr) begin
        mismatches++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display(
            "[%0t] mismatch: pos exp %0d act %0d, char exp %02h act %02h, attr exp %02h act %02h",
            $time, want.cursor_pos, got.cursor_pos, want.cell_char, got.cell_char,
            want.cell_attr, got.cell_attr);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;

  tcw_item_if   item_ch ();
  tcw_result_if res_ch ();

  console_scoreboard sb = new();

  text_console_char_writer DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: sample the transaction at the edge, then pick the next ready.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.cursor_pos, res_ch.cell_char, res_ch.cell_attr});
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= k;
    item_ch.char_code  <= ch;
    item_ch.cell_index <= idx;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(k, ch, idx);
  endtask

  // Hold the input idle until every expected result has arrived.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int unsigned        r;
    int unsigned        back;
    int unsigned        cur;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;

    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.kind       = KIND_PUT;
    item_ch.char_code  = '0;
    item_ch.cell_index = '0;
    res_ch.ready       = 1'b0;
    tx_idle_pct        = 34;
    rx_idle_pct        = 54;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every kind, control bytes and edge cells.
    send_item(KIND_PUT, 8'h41, 11'd0);
    send_item(KIND_PUT, 8'h00, 11'd0);
    send_item(KIND_PUT, 8'hFF, 11'h7FF);
    send_item(KIND_PUT, 8'h07, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hFF, 11'd3);
    send_item(KIND_PUT, CH_BS, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd3);
    send_item(KIND_PUT, CH_CR, 11'd0);
    send_item(KIND_PUT, CH_BS, 11'd0);
    send_item(KIND_PUT, CH_NL, 11'd0);
    send_item(KIND_PUT, 8'h80, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd80);
    send_item(KIND_READ, 8'h00, INDEX_W'(CELLS - 1));
    send_item(KIND_READ, 8'h00, INDEX_W'(CELLS));
    send_item(KIND_READ, 8'hFF, 11'h7FF);
    send_item(KIND_UNUSED, 8'hFF, 11'h7FF);
    send_item(KIND_CLEAR, 8'hFF, 11'h7FF);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_PUT, 8'h55, 11'd0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 54;
        end
        1: begin
          tx_idle_pct = 54;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        r   = $urandom_range(999);
        ch  = CHAR_W'($urandom_range(255));
        idx = INDEX_W'($urandom_range(2047));
        // Few clears so the cursor keeps reaching the bottom row and scrolls.
        if (r < 500) begin
          send_item(KIND_PUT, ch, idx);
        end else if (r < 650) begin
          send_item(KIND_PUT, CH_NL, idx);
        end else if (r < 700) begin
          send_item(KIND_PUT, CH_CR, idx);
        end else if (r < 780) begin
          send_item(KIND_PUT, CH_BS, idx);
        end else if (r < 785) begin
          send_item(KIND_CLEAR, ch, idx);
        end else if (r < 975) begin
          // read near the cursor half the time, where text was just written
          if ($urandom_range(1)) begin
            cur  = 32'(sb.cursor());
            back = $urandom_range(2 * COLUMNS);
            idx  = (cur > back) ? INDEX_W'(cur - back) : '0;
          end
          send_item(KIND_READ, ch, idx);
        end else begin
          send_item(KIND_UNUSED, ch, idx);
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d results checked; %0d scrolls, %0d clears, %0d reads (%0d off screen)",
             sb.checked, sb.scrolls, sb.clears, sb.reads, sb.off_screen_reads);
    $display("mismatches %0d, unexpected results %0d, missing results %0d",
             sb.mismatches, sb.unexpected, sb.pending.size());
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0) begin
      $display("text_console_char_writer verification clean");
    end else begin
      $display("text_console_char_writer verification failed");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("text_console_char_writer verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/tcw_pkg.sv
hdl/tcw_item_if.sv
hdl/tcw_result_if.sv
hdl/tcw_datapath.sv
hdl/tcw_controller.sv
hdl/text_console_char_writer.sv
tb/tb_text_console_char_writer.sv
